// ===== src/lzss_pkg.sv =====
// ----------------------------------------------------------------------------
// LZSS ring decompressor package
// Shared types, codes and sizes for the decompressor's front end, command
// queue, back end and ring memory.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam logic [8:0] FLAG_EMPTY = 9'h001;
  localparam logic [8:0] FLAG_MARK  = 9'h100;
  localparam int         MIN_RUN    = 3;

  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_AW      = $clog2(CMDQ_DEPTH);
  localparam int CQ_CW      = $clog2(CMDQ_DEPTH + 1);

  localparam int OUTQ_DEPTH = 4;
  localparam int OQ_AW      = $clog2(OUTQ_DEPTH);
  localparam int OQ_CW      = $clog2(OUTQ_DEPTH + 1);

  // command kinds passed from front to back
  localparam logic [1:0] CMD_LIT  = 2'd0;
  localparam logic [1:0] CMD_COPY = 2'd1;
  localparam logic [1:0] CMD_MARK = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;
  } out_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         lit;
    logic [RING_AW-1:0] off;
    logic [3:0]         len_m3;
    logic               last;
  } cmd_t;

endpackage

// ===== src/lzss_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lzss_front.sv =====
// ----------------------------------------------------------------------------
// LZSS front end
// Parses compressed bytes: flag bytes, literals, back reference halves and
// the end marker, and turns each completed token into a command.
// ----------------------------------------------------------------------------
module lzss_front
  import lzss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  in_t  item,
  output logic cmd_push,
  output cmd_t cmd
);

  logic [8:0] flag_shift, flag_shift_next;
  logic       expect_low, expect_low_next;
  logic [7:0] held_hi, held_hi_next;
  logic       stopped, stopped_next;
  logic [RING_AW-1:0] off;

  assign off = {held_hi, item.in_byte[7:4]};

  always_comb begin
    flag_shift_next = flag_shift;
    expect_low_next = expect_low;
    held_hi_next    = held_hi;
    stopped_next    = stopped;
    cmd_push        = 1'b0;
    cmd.kind        = CMD_MARK;
    cmd.lit         = item.in_byte;
    cmd.off         = off;
    cmd.len_m3      = item.in_byte[3:0];
    cmd.last        = item.last_byte;

    if (take && !stopped) begin
      if (expect_low) begin
        expect_low_next = 1'b0;
        cmd_push        = 1'b1;
        if (off == '0) begin
          stopped_next = 1'b1;
        end else begin
          cmd.kind     = CMD_COPY;
          stopped_next = item.last_byte;
        end
      end else if (flag_shift == FLAG_EMPTY) begin
        flag_shift_next = FLAG_MARK | {1'b0, item.in_byte};
        cmd_push        = item.last_byte;
        stopped_next    = item.last_byte;
      end else begin
        flag_shift_next = flag_shift >> 1;
        if (flag_shift[0]) begin
          cmd.kind     = CMD_LIT;
          cmd_push     = 1'b1;
          stopped_next = item.last_byte;
        end else begin
          held_hi_next    = item.in_byte;
          expect_low_next = 1'b1;
          cmd_push        = item.last_byte;
          stopped_next    = item.last_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_shift <= FLAG_EMPTY;
      expect_low <= 1'b0;
      held_hi    <= '0;
      stopped    <= 1'b0;
    end else begin
      flag_shift <= flag_shift_next;
      expect_low <= expect_low_next;
      held_hi    <= held_hi_next;
      stopped    <= stopped_next;
    end
  end

endmodule

// ===== src/lzss_cmdq.sv =====
// ----------------------------------------------------------------------------
// LZSS command queue
// Short FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module lzss_cmdq
  import lzss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  input  logic rd,
  output cmd_t head,
  output logic avail,
  output logic full
);

  cmd_t             slot [CMDQ_DEPTH];
  logic [CQ_AW-1:0] wptr, rptr;
  logic [CQ_CW-1:0] count;

  assign head  = slot[rptr];
  assign avail = (count != '0);
  assign full  = (count == CQ_CW'(CMDQ_DEPTH));

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= CQ_AW'(wptr + 1'b1);
      end
      if (rd) begin
        rptr <= CQ_AW'(rptr + 1'b1);
      end
      count <= CQ_CW'(count + CQ_CW'(wr) - CQ_CW'(rd));
    end
  end

endmodule

// ===== src/lzss_back.sv =====
// ----------------------------------------------------------------------------
// LZSS back end
// Executes commands one output byte per cycle while the output queue has
// room: issue stage reads the ring, write stage writes the ring and pushes
// the result into the output queue.
module lzss_back
  import lzss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_avail,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic empty,
  input  logic pop,
  output out_t result
);

  // issue stage
  logic [4:0]         cnt;
  logic [RING_AW-1:0] src;
  logic [4:0]         len_full, cnt_plus;
  logic               is_copy, done, room, issue;
  logic [RING_AW-1:0] wp_eff, raddr;
  logic               collide, rd_ok;

  // write stage
  logic               s2_valid;
  logic [1:0]         s2_kind;
  logic [7:0]         s2_lit;
  logic               s2_done, s2_last, s2_rd_ok, s2_coll;
  logic [7:0]         s2_cdata;
  logic [7:0]         rdata, s2_data;
  logic               we;
  logic [RING_AW-1:0] wpos;
  logic               filled;
  out_t               s2_res;

  // output queue
  out_t               oq [OUTQ_DEPTH];
  logic [OQ_AW-1:0]   oq_wptr, oq_rptr;
  logic [OQ_CW-1:0]   oq_count;
  logic               oq_pop;

  assign len_full = {1'b0, cmd.len_m3} + 5'(MIN_RUN);
  assign cnt_plus = cnt + 5'd1;
  assign is_copy  = (cmd.kind == CMD_COPY);
  assign done     = !is_copy || (cnt_plus == len_full);
  // count the result still in the write stage as taken
  assign room     = ({1'b0, oq_count} + {{OQ_CW{1'b0}}, s2_valid}) < (OQ_CW + 1)'(OUTQ_DEPTH);
  assign issue    = cmd_avail && room;
  assign cmd_pop  = issue && done;

  assign we      = s2_valid && (s2_kind != CMD_MARK);
  assign wp_eff  = RING_AW'(wpos + RING_AW'(we));
  assign raddr   = (cnt == '0) ? RING_AW'(wp_eff - cmd.off) : src;
  assign collide = we && (raddr == wpos);
  // slots not yet written since reset read as zero
  assign rd_ok   = filled || (raddr < wpos) || collide;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= issue;
      if (issue) begin
        cnt <= done ? 5'd0 : cnt_plus;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      src      <= RING_AW'(raddr + 1'b1);
      s2_kind  <= cmd.kind;
      s2_lit   <= cmd.lit;
      s2_done  <= done;
      s2_last  <= cmd.last;
      s2_rd_ok <= rd_ok;
      s2_coll  <= collide;
      s2_cdata <= s2_data;
    end
  end

  lzss_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (we),
    .waddr(wpos),
    .wdata(s2_data),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    s2_data = 8'h00;
    s2_res  = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, stream_end: 1'b1};
    unique case (s2_kind)
      CMD_LIT: begin
        s2_data = s2_lit;
        s2_res  = '{out_byte: s2_lit, byte_valid: 1'b1, run_last: 1'b1,
                    stream_end: s2_last};
      end
      CMD_COPY: begin
        if (s2_coll) begin
          s2_data = s2_cdata;
        end else if (s2_rd_ok) begin
          s2_data = rdata;
        end
        s2_res = '{out_byte: s2_data, byte_valid: 1'b1, run_last: s2_done,
                   stream_end: s2_last && s2_done};
      end
      default: begin
        s2_data = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos   <= '0;
      filled <= 1'b0;
    end else if (we) begin
      wpos <= RING_AW'(wpos + 1'b1);
      if (wpos == '1) begin
        filled <= 1'b1;
      end
    end
  end

  assign empty  = (oq_count == '0);
  assign result = oq[oq_rptr];
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      oq[oq_wptr] <= s2_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= '0;
      oq_rptr  <= '0;
      oq_count <= '0;
    end else begin
      if (s2_valid) begin
        oq_wptr <= OQ_AW'(oq_wptr + 1'b1);
      end
      if (oq_pop) begin
        oq_rptr <= OQ_AW'(oq_rptr + 1'b1);
      end
      oq_count <= OQ_CW'(oq_count + OQ_CW'(s2_valid) - OQ_CW'(oq_pop));
    end
  end

endmodule

// ===== src/lzss_ring_decompressor.sv =====
// ----------------------------------------------------------------------------
// LZSS ring decompressor, 4 KiB window
// Input queue side: push an item {in_byte, last_byte} while full is low; one
// compressed byte per transaction. Result queue side: while empty is low the
// oldest result {out_byte, byte_valid, run_last, stream_end} is on result;
// pop takes it. Flag bytes and the high half of a back reference give no
// result unless they carry last_byte.
// A literal goes through the command queue, write stage and result queue.
// Throughput: one input transaction per cycle into the 2-entry command queue;
// the back end produces one result per cycle while the result queue has room,
// 1 per literal and 3 to 18 per back reference, read byte by byte via the
// single ring read port, so overlapping copies repeat fresh bytes.
// Reset clears the parser, queues and ring write pointer; ring slots not yet
// written since reset read as zero, with no clearing pass.
// When the receiver stalls, the 4-entry result queue fills, the back end
// holds, the command queue fills and full rises. Input after the stream end
// is taken and dropped.
// ----------------------------------------------------------------------------
module lzss_ring_decompressor
  import lzss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output out_t result
);

  logic take;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_avail;
  logic cmd_pop;

  assign take = push && !full;

  lzss_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (item),
    .cmd_push(cmd_push),
    .cmd     (cmd_in)
  );

  lzss_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wr_cmd(cmd_in),
    .rd    (cmd_pop),
    .head  (cmd_head),
    .avail (cmd_avail),
    .full  (full)
  );

  lzss_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_avail(cmd_avail),
    .cmd      (cmd_head),
    .cmd_pop  (cmd_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ===== src/lzss_checker.sv =====
// ----------------------------------------------------------------------------
// LZSS decompressor port checker
// Watches the top level's ports for result framing and queue behavior.
// ----------------------------------------------------------------------------
module lzss_checker
  import lzss_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input out_t result
);

  // result queue comes out of reset drained
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a result without a byte only ever closes the stream
  a_nobyte_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.byte_valid) |-> (result.run_last && result.stream_end
      && result.out_byte == 8'h00))
    else $error("empty result that does not end the stream");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.stream_end) |-> result.run_last)
    else $error("stream end on a result that is not the last of its item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

endmodule

bind lzss_ring_decompressor lzss_checker u_chk (.*);
